// ----- hw/rtl/bsd_pkg.sv -----
`timescale 1ns / 1ps

package bsd_pkg;

	// Default image size limits handed to the top level.
	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;

	// Header layout and checks.
	localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
	localparam logic [15:0] BMP_BPP_24     = 16'd24;
	localparam logic [31:0] BMP_HEADER_LEN = 32'd54;

	// Result kinds.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// Error codes.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
	localparam logic [2:0] ERR_NOT_24BIT  = 3'd2;
	localparam logic [2:0] ERR_COMPRESSED = 3'd3;
	localparam logic [2:0] ERR_OFFSET     = 3'd4;
	localparam logic [2:0] ERR_SIZE       = 3'd5;

	// One result word, as it leaves the parser and waits in the output stage.
	typedef struct packed {
		logic        kind;
		logic [2:0]  error_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] row_from_top;
		logic [23:0] pixel_index;
		logic        last_pixel;
	} bsd_result_t;

endpackage

// ----- hw/rtl/bmp24_stream_decoder.sv -----
`timescale 1ns / 1ps

// Decoder for uncompressed 24-bit BMP files delivered one byte per input word,
// with s_tuser set on the first byte of each file. It reads the packed file
// and info headers, checks the signature, 24 bits per pixel, no compression,
// a pixel offset of at least 54 and a positive size within MAX_WIDTH by
// MAX_HEIGHT, and sends one error word on the first failed check. Otherwise
// it skips to the pixel offset and sends one pixel word per stored B,G,R
// triple, bottom row first, with the row flipped to count from the top and
// m_tlast on the final pixel; row padding is dropped. The parser is a set of
// counters and compares that updates on each accepted byte, and a two-entry
// output stage keeps s_tready high while one result waits on m_tready.
// Header bytes, skipped bytes and padding give no output; bytes after an
// error or after the image are ignored until the next start of file.

module bmp24_stream_decoder #(
	parameter int MAX_WIDTH  = bsd_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bsd_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] start_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] error_code, [10:3] red, [18:11] green, [26:19] blue, [38:27] column,
	// [50:39] row_from_top, [74:51] pixel_index, [79:75] zero
	output logic [79:0] m_tdata,
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast    // last_pixel
);
	import bsd_pkg::*;

	logic        step;
	logic        res_valid;
	bsd_result_t res;
	bsd_result_t out_res;

	assign step = s_tvalid && s_tready;

	// Byte parser.
	bsd_parser #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (s_tdata),
		.start_of_file(s_tuser),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output register with a spare slot.
	bsd_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_data (out_res),
		.out_ready(m_tready)
	);

	// Pack the result word onto the stream.
	assign m_tdata = {5'b00000, out_res.pixel_index, out_res.row_from_top, out_res.column,
		out_res.blue, out_res.green, out_res.red, out_res.error_code};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_pixel;

endmodule

// ----- hw/rtl/bsd_parser.sv -----
`timescale 1ns / 1ps

module bsd_parser #(
	parameter int MAX_WIDTH  = bsd_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bsd_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                start_of_file,
	output logic                res_valid,
	output bsd_pkg::bsd_result_t res
);
	import bsd_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_PIXELS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// Merge one byte into a little-endian 32-bit field at the given lane.
	function automatic logic [31:0] place_byte(input logic [31:0] word, input logic [7:0] b,
			input logic [1:0] lane);
		place_byte = word | (32'(b) << {lane, 3'b000});
	endfunction

	// A size is bad when zero, negative as a signed word, or beyond its limit.
	function automatic logic size_bad(input logic [31:0] v, input logic [31:0] limit);
		size_bad = (v == 32'd0) || v[31] || (v > limit);
	endfunction

	logic [2:0]       phase_q, phase_e, phase_n;
	logic [31:0]      pos_q, pos_e, pos_n;
	logic [31:0]      offset_q, offset_e, offset_n;
	logic [31:0]      width_q, width_e, width_n;
	logic [31:0]      height_q, height_e, height_n;
	logic [15:0]      check_q, check_e, check_n;
	logic [1:0]       sub_q, sub_e, sub_n;
	logic [COL_W-1:0] col_q, col_e, col_n;
	logic [ROW_W-1:0] row_q, row_e, row_n;
	logic             in_pad_q, in_pad_e, in_pad_n;
	logic [1:0]       pad_cnt_q, pad_cnt_e, pad_cnt_n;
	logic [1:0]       pad_len_q, pad_len_e, pad_len_n;
	logic [15:0]      held_q, held_e, held_n;
	logic [11:0]      top_q, top_n;
	logic [23:0]      row_start_q, row_start_n;

	logic [47:0] start_prod;
	logic [31:0] col_ext;
	logic [1:0]  lane;
	logic [15:0] word29;
	logic        col_last;
	logic        row_last;
	logic        row_end;

	// Index of the first pixel of the first file row (the bottom image row), ready long before pixels arrive.
	assign start_prod = (48'(height_q[23:0]) - 48'd1) * 48'(width_q[23:0]);

	assign col_ext  = 32'(col_e);
	assign lane     = pos_e[1:0] + 2'd2;
	assign word29   = {data_byte, check_e[7:0]};
	assign col_last = (col_ext + 32'd1) == width_e;
	assign row_last = (32'(row_e) + 32'd1) == height_e;

	// A start of file clears the parse state before the byte is handled.
	always_comb begin
		phase_e   = start_of_file ? PH_HEADER : phase_q;
		pos_e     = start_of_file ? 32'd0 : pos_q;
		offset_e  = start_of_file ? 32'd0 : offset_q;
		width_e   = start_of_file ? 32'd0 : width_q;
		height_e  = start_of_file ? 32'd0 : height_q;
		check_e   = start_of_file ? 16'd0 : check_q;
		sub_e     = start_of_file ? 2'd0 : sub_q;
		col_e     = start_of_file ? '0 : col_q;
		row_e     = start_of_file ? '0 : row_q;
		in_pad_e  = start_of_file ? 1'b0 : in_pad_q;
		pad_cnt_e = start_of_file ? 2'd0 : pad_cnt_q;
		pad_len_e = start_of_file ? 2'd0 : pad_len_q;
		held_e    = start_of_file ? 16'd0 : held_q;
	end

	// Per-byte parse: header fields, skip to the pixel offset, then B,G,R triples.
	always_comb begin
		phase_n     = phase_e;
		pos_n       = pos_e;
		offset_n    = offset_e;
		width_n     = width_e;
		height_n    = height_e;
		check_n     = check_e;
		sub_n       = sub_e;
		col_n       = col_e;
		row_n       = row_e;
		in_pad_n    = in_pad_e;
		pad_cnt_n   = pad_cnt_e;
		pad_len_n   = pad_len_e;
		held_n      = held_e;
		top_n       = top_q;
		row_start_n = row_start_q;
		row_end     = 1'b0;
		res_valid   = 1'b0;
		res         = '0;

		unique case (phase_e)
			PH_HEADER: begin
				pos_n = pos_e + 32'd1;
				if (pos_e < 32'd2) begin
					check_n = check_e | (pos_e[0] ? {data_byte, 8'h00} : {8'h00, data_byte});
					if (pos_e == 32'd1 && check_n != BMP_SIGNATURE) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_SIGNATURE;
						phase_n        = PH_DONE;
					end
				end else if (pos_e >= 32'd10 && pos_e <= 32'd13) begin
					offset_n = place_byte(offset_e, data_byte, lane);
				end else if (pos_e >= 32'd18 && pos_e <= 32'd21) begin
					width_n = place_byte(width_e, data_byte, lane);
				end else if (pos_e >= 32'd22 && pos_e <= 32'd25) begin
					height_n = place_byte(height_e, data_byte, lane);
				end else if (pos_e == 32'd26) begin
					// Width and height are complete; seed the top-row counters.
					top_n       = height_q[11:0] - 12'd1;
					row_start_n = start_prod[23:0];
				end else if (pos_e == 32'd28) begin
					check_n = {8'h00, data_byte};
				end else if (pos_e == 32'd29) begin
					if (word29 != BMP_BPP_24) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NOT_24BIT;
						phase_n        = PH_DONE;
					end else begin
						check_n = 16'd0;
					end
				end else if (pos_e >= 32'd30 && pos_e <= 32'd33) begin
					check_n = check_e | {8'h00, data_byte};
					if (pos_e == 32'd33 && check_n != 16'd0) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_COMPRESSED;
						phase_n        = PH_DONE;
					end
				end else if (pos_e == BMP_HEADER_LEN - 32'd1) begin
					if (offset_e < BMP_HEADER_LEN) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_OFFSET;
						phase_n        = PH_DONE;
					end else if (size_bad(width_e, 32'(MAX_WIDTH)) ||
							size_bad(height_e, 32'(MAX_HEIGHT))) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_SIZE;
						phase_n        = PH_DONE;
					end else begin
						pad_len_n = width_e[1:0];
						phase_n   = (offset_e == BMP_HEADER_LEN) ? PH_PIXELS : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if ({1'b0, pos_e} + 33'd1 >= {1'b0, offset_e}) begin
					phase_n = PH_PIXELS;
				end
				pos_n = pos_e + 32'd1;
			end
			PH_PIXELS: begin
				if (!in_pad_e) begin
					case (sub_e)
						2'd0: begin
							held_n = {8'h00, data_byte};
							sub_n  = 2'd1;
						end
						2'd1: begin
							held_n = {data_byte, held_e[7:0]};
							sub_n  = 2'd2;
						end
						default: begin
							res_valid        = 1'b1;
							res.kind         = KIND_PIXEL;
							res.error_code   = ERR_NONE;
							res.red          = data_byte;
							res.green        = held_e[15:8];
							res.blue         = held_e[7:0];
							res.column       = col_ext[11:0];
							res.row_from_top = top_q;
							res.pixel_index  = row_start_q + col_ext[23:0];
							res.last_pixel   = row_last && col_last;
							sub_n            = 2'd0;
							col_n            = col_e + 1'b1;
							if (col_last) begin
								if (pad_len_e == 2'd0) begin
									row_end = 1'b1;
								end else begin
									in_pad_n  = 1'b1;
									pad_cnt_n = 2'd0;
								end
							end
						end
					endcase
				end else begin
					// Padding bytes round the row up to a multiple of four.
					if (pad_cnt_e + 2'd1 == pad_len_e) begin
						row_end = 1'b1;
					end else begin
						pad_cnt_n = pad_cnt_e + 2'd1;
					end
				end

				// Step to the next file row, one row up in the image.
				if (row_end) begin
					sub_n       = 2'd0;
					col_n       = '0;
					in_pad_n    = 1'b0;
					pad_cnt_n   = 2'd0;
					row_n       = row_e + 1'b1;
					top_n       = top_q - 12'd1;
					row_start_n = row_start_q - width_e[23:0];
					if (row_last) begin
						phase_n = PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase

		if (!step) begin
			res_valid = 1'b0;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= 32'd0;
			offset_q    <= 32'd0;
			width_q     <= 32'd0;
			height_q    <= 32'd0;
			check_q     <= 16'd0;
			sub_q       <= 2'd0;
			col_q       <= '0;
			row_q       <= '0;
			in_pad_q    <= 1'b0;
			pad_cnt_q   <= 2'd0;
			pad_len_q   <= 2'd0;
			held_q      <= 16'd0;
			top_q       <= 12'd0;
			row_start_q <= 24'd0;
		end else if (step) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			offset_q    <= offset_n;
			width_q     <= width_n;
			height_q    <= height_n;
			check_q     <= check_n;
			sub_q       <= sub_n;
			col_q       <= col_n;
			row_q       <= row_n;
			in_pad_q    <= in_pad_n;
			pad_cnt_q   <= pad_cnt_n;
			pad_len_q   <= pad_len_n;
			held_q      <= held_n;
			top_q       <= top_n;
			row_start_q <= row_start_n;
		end
	end

endmodule

// ----- hw/rtl/bsd_out_skid.sv -----
`timescale 1ns / 1ps

module bsd_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  bsd_pkg::bsd_result_t in_data,
	output logic                 in_ready,
	output logic                 out_valid,
	output bsd_pkg::bsd_result_t out_data,
	input  logic                 out_ready
);
	import bsd_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	bsd_result_t out_data_q;
	bsd_result_t skid_data_q;

	// Upstream may send as long as the spare slot is free.
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control: main slot and spare slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// Payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (!out_valid_q || out_ready) begin
				out_data_q <= in_data;
			end else begin
				skid_data_q <= in_data;
			end
		end else if (out_ready && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

endmodule

// ----- dv/bmp24_stream_decoder_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels of the decoder. Every accepted input byte runs
// through a local model of the BMP parser, and every word that model produces
// is queued. Every accepted output word is checked against the oldest queued
// word.
module bmp24_stream_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_count,
	output int          pixel_count,
	output int          error_count
);

	import bsd_pkg::*;

	typedef enum logic [2:0] {
		WAIT_SOF,
		READ_HEADER,
		SKIP_GAP,
		READ_PIXELS,
		IGNORE_REST
	} parse_phase_t;

	localparam int REPORT_LIMIT = 10;

	// Model state of the parser.
	parse_phase_t phase;
	logic [31:0]  byte_count;
	logic [31:0]  data_start;
	logic [31:0]  img_w;
	logic [31:0]  img_h;
	logic [15:0]  check_word;
	logic [31:0]  row_byte;
	logic [31:0]  col;
	logic [31:0]  file_row;
	logic [15:0]  held_bg;
	logic [1:0]   row_pad;

	bsd_result_t expected_q[$];
	int          mismatches;
	int          pixels_ok;
	int          errors_ok;

	function automatic string word_text(input bsd_result_t w);
		return $sformatf("kind %0d code %0d rgb %02h_%02h_%02h col %0d row %0d index %0d last %0d",
			w.kind, w.error_code, w.red, w.green, w.blue, w.column, w.row_from_top,
			w.pixel_index, w.last_pixel);
	endfunction

	// A size field fails when it is zero, negative as a signed value, or over the limit.
	function automatic bit size_out_of_range(input logic [31:0] v, input logic [31:0] limit);
		return v == 32'd0 || v[31] || v > limit;
	endfunction

	task automatic clear_image_state();
		byte_count   = '0;
		data_start   = '0;
		img_w        = '0;
		img_h        = '0;
		check_word   = '0;
		row_byte     = '0;
		col          = '0;
		file_row     = '0;
		held_bg      = '0;
		row_pad      = '0;
	endtask

	// Advances the model by one input byte and queues the word it causes, if any.
	task automatic decode_byte(input logic [7:0] b, input logic sof);
		logic [31:0] p;
		logic [31:0] row_len;
		logic [31:0] sub;
		logic [31:0] top;
		logic [2:0]  err;
		bsd_result_t r;
		err = ERR_NONE;
		r   = '0;
		if (sof) begin
			clear_image_state();
			phase = READ_HEADER;
		end
		case (phase)
			READ_HEADER: begin
				p = byte_count;
				byte_count = p + 1;
				if (p < 2) begin
					check_word = check_word | (16'(b) << (8 * p));
					if (p == 1 && check_word != BMP_SIGNATURE)
						err = ERR_SIGNATURE;
				end else if (p >= 10 && p <= 13) begin
					data_start = data_start | (32'(b) << (8 * (p - 10)));
				end else if (p >= 18 && p <= 21) begin
					img_w = img_w | (32'(b) << (8 * (p - 18)));
				end else if (p >= 22 && p <= 25) begin
					img_h = img_h | (32'(b) << (8 * (p - 22)));
				end else if (p == 28) begin
					check_word = 16'(b);
				end else if (p == 29) begin
					check_word = {b, check_word[7:0]};
					if (check_word != BMP_BPP_24)
						err = ERR_NOT_24BIT;
					check_word = '0;
				end else if (p >= 30 && p <= 33) begin
					// Any set bit in the four compression bytes is a failure.
					check_word = check_word | 16'(b);
					if (p == 33 && check_word != 16'd0)
						err = ERR_COMPRESSED;
				end else if (p == BMP_HEADER_LEN - 1) begin
					if (data_start < BMP_HEADER_LEN) begin
						err = ERR_OFFSET;
					end else if (size_out_of_range(img_w, DEFAULT_MAX_WIDTH) ||
					             size_out_of_range(img_h, DEFAULT_MAX_HEIGHT)) begin
						err = ERR_SIZE;
					end else begin
						row_pad = img_w[1:0];
						phase = (data_start == BMP_HEADER_LEN) ? READ_PIXELS : SKIP_GAP;
					end
				end
				if (err != ERR_NONE) begin
					r.kind       = KIND_ERROR;
					r.error_code = err;
					expected_q.push_back(r);
					phase = IGNORE_REST;
				end
			end
			SKIP_GAP: begin
				if ({1'b0, byte_count} + 33'd1 >= {1'b0, data_start})
					phase = READ_PIXELS;
				byte_count = byte_count + 1;
			end
			READ_PIXELS: begin
				row_len = 3 * img_w;
				if (row_byte < row_len) begin
					sub = row_byte - 3 * col;
					if (sub == 0) begin
						held_bg = {8'd0, b};
					end else if (sub == 1) begin
						held_bg = {b, held_bg[7:0]};
					end else begin
						top = img_h - 1 - file_row;
						r.kind         = KIND_PIXEL;
						r.error_code   = ERR_NONE;
						r.red          = b;
						r.green        = held_bg[15:8];
						r.blue         = held_bg[7:0];
						r.column       = col[11:0];
						r.row_from_top = top[11:0];
						r.pixel_index  = 24'(top * img_w + col);
						r.last_pixel   = (file_row + 1 == img_h) && (col + 1 == img_w);
						expected_q.push_back(r);
						col = col + 1;
					end
				end
				// Padding bytes close the row without producing a word.
				if (row_byte + 1 >= row_len + 32'(row_pad)) begin
					row_byte = '0;
					col      = '0;
					file_row = file_row + 1;
					if (file_row >= img_h)
						phase = IGNORE_REST;
				end else begin
					row_byte = row_byte + 1;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Output words are compared before the input byte of the same edge is modeled.
	always @(posedge clk or negedge arst_n) begin : watch
		bsd_result_t seen;
		bsd_result_t want;
		if (!arst_n) begin
			clear_image_state();
			phase = WAIT_SOF;
			expected_q.delete();
			mismatches = 0;
			pixels_ok  = 0;
			errors_ok  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.kind         = m_tuser;
				seen.error_code   = m_tdata[2:0];
				seen.red          = m_tdata[10:3];
				seen.green        = m_tdata[18:11];
				seen.blue         = m_tdata[26:19];
				seen.column       = m_tdata[38:27];
				seen.row_from_top = m_tdata[50:39];
				seen.pixel_index  = m_tdata[74:51];
				seen.last_pixel   = m_tlast;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: output word with nothing expected: %s",
							$time, word_text(seen));
				end else begin
					want = expected_q.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: wrong output word", $time);
							$display("  expected %s", word_text(want));
							$display("  actual   %s", word_text(seen));
						end
					end else if (want.kind == KIND_ERROR) begin
						errors_ok++;
					end else begin
						pixels_ok++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
		end
		fail_count    <= mismatches;
		pending_count <= expected_q.size();
		pixel_count   <= pixels_ok;
		error_count   <= errors_ok;
	end

endmodule

// ----- dv/bmp24_stream_decoder_tb.sv -----
`timescale 1ns / 1ps

module bmp24_stream_decoder_tb;

	import bsd_pkg::*;

	localparam int RUN_LIMIT    = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_STALL   = 200;
	localparam int MAX_GAP      = 64;
	localparam int PHASE_BYTES  = 60;

	// One byte of the file stream and its start-of-file mark.
	typedef struct packed {
		logic       sof;
		logic [7:0] data;
	} stream_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending_count;
	int pixel_count;
	int error_count;

	stream_byte_t byte_q[$];
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	bit           stall_armed   = 1'b0;
	int           file_count    = 0;
	int           byte_total    = 0;
	int           cycle_count   = 0;

	bmp24_stream_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bmp24_stream_decoder_checker pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.pixel_count   (pixel_count),
		.error_count   (error_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold-off once armed and words flow.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_armed && m_tvalid) begin
				stall_armed = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_STALL - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit with %0d words still expected.",
			pending_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Builds one file: the 54 header bytes with the given fields and random filler,
	// the gap up to the pixel offset, the pixel rows with padding and trailing bytes.
	// A positive keep cuts the file short after that many bytes.
	task automatic add_file(input logic [15:0] sig, input logic [31:0] offset,
	                        input logic [31:0] width, input logic [31:0] height,
	                        input logic [15:0] bpp, input logic [31:0] comp,
	                        input int keep, input int junk);
		logic [7:0] img[$];
		int         gap;
		int         n;
		for (int i = 0; i < BMP_HEADER_LEN; i++)
			img.push_back(8'($urandom));
		img[0]  = sig[7:0];
		img[1]  = sig[15:8];
		img[28] = bpp[7:0];
		img[29] = bpp[15:8];
		for (int k = 0; k < 4; k++) begin
			img[10 + k] = offset[8 * k +: 8];
			img[18 + k] = width[8 * k +: 8];
			img[22 + k] = height[8 * k +: 8];
			img[30 + k] = comp[8 * k +: 8];
		end
		// An unreachable offset gets a short run of bytes that are only skipped.
		if (offset >= BMP_HEADER_LEN && offset <= BMP_HEADER_LEN + MAX_GAP)
			gap = offset - BMP_HEADER_LEN;
		else if (offset > BMP_HEADER_LEN)
			gap = 12;
		else
			gap = 0;
		for (int i = 0; i < gap; i++)
			img.push_back(8'($urandom));
		if (sig == BMP_SIGNATURE && bpp == BMP_BPP_24 && comp == 32'd0 &&
		    offset >= BMP_HEADER_LEN && offset <= BMP_HEADER_LEN + MAX_GAP &&
		    width >= 1 && width <= DEFAULT_MAX_WIDTH &&
		    height >= 1 && height <= DEFAULT_MAX_HEIGHT) begin
			for (int r = 0; r < height; r++)
				for (int c = 0; c < 3 * width + (width & 3); c++)
					img.push_back(8'($urandom));
		end
		for (int i = 0; i < junk; i++)
			img.push_back(8'($urandom));
		n = (keep > 0 && keep < img.size()) ? keep : img.size();
		for (int i = 0; i < n; i++)
			byte_q.push_back({(i == 0), img[i]});
		file_count++;
		byte_total += n;
	endtask

	// Mostly well-formed small images; some are cut short, some carry one broken
	// header field, and a few stray bytes fall between files.
	task automatic add_random_file();
		logic [15:0] sig;
		logic [15:0] bpp;
		logic [31:0] offset;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] comp;
		int          keep;
		int          junk;
		int          pick;
		int          strays;
		sig    = BMP_SIGNATURE;
		bpp    = BMP_BPP_24;
		comp   = 32'd0;
		width  = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
		height = $urandom_range(1, 4);
		offset = BMP_HEADER_LEN + (($urandom_range(3) == 0) ? $urandom_range(1, 10) : 0);
		junk   = $urandom_range(0, 3);
		keep   = -1;
		pick   = $urandom_range(99);
		if (pick < 12) begin
			keep = $urandom_range(1, BMP_HEADER_LEN + 3 * width * height);
		end else if (pick < 30) begin
			case ($urandom_range(5))
				0: sig    = 16'($urandom);
				1: bpp    = 16'($urandom);
				2: comp   = 32'($urandom) >> (8 * $urandom_range(3));
				3: offset = $urandom_range(0, BMP_HEADER_LEN - 1);
				4: width  = $urandom;
				default: height = $urandom_range(1) ? -$urandom_range(1, 4096) : $urandom;
			endcase
		end else if (pick >= 94) begin
			strays = $urandom_range(1, 4);
			for (int i = 0; i < strays; i++)
				byte_q.push_back({($urandom_range(3) == 0), 8'($urandom)});
			byte_total += strays;
		end
		add_file(sig, offset, width, height, bpp, comp, keep, junk);
	endtask

	task automatic add_random_files(input int budget);
		int start;
		start = byte_total;
		while (byte_total - start < budget)
			add_random_file();
	endtask

	// Sender: offers queued bytes with random gaps and holds each word until taken.
	task automatic send_queued();
		stream_byte_t w;
		bit           busy;
		busy = s_tvalid;
		while (byte_q.size() > 0 || busy) begin
			@(posedge clk);
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					w = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= w.data;
					s_tuser  <= w.sof;
					busy = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
					busy = 1'b0;
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 26;
		recv_idle_pct = 51;

		// Bytes before any start of file are dropped.
		for (int i = 0; i < 3; i++)
			byte_q.push_back({1'b0, 8'($urandom)});
		byte_total += 3;

		// Well-formed images covering each nonzero padding length, a gap and trailing bytes.
		add_file(BMP_SIGNATURE, 54, 1, 1, BMP_BPP_24, 0, -1, 2);
		add_file(BMP_SIGNATURE, 60, 2, 2, BMP_BPP_24, 0, -1, 0);
		add_file(BMP_SIGNATURE, 54, 3, 1, BMP_BPP_24, 0, -1, 0);
		// Each header check; early failures are cut a few bytes after the failing byte.
		add_file(16'h4E42, 54, 2, 2, BMP_BPP_24, 0, 4, 0);
		add_file(16'h4D43, 54, 2, 2, BMP_BPP_24, 0, 4, 0);
		add_file(BMP_SIGNATURE, 54, 2, 2, 16'h0118, 0, 32, 0);
		add_file(BMP_SIGNATURE, 54, 2, 2, BMP_BPP_24, 32'h0100_0000, 36, 0);
		add_file(BMP_SIGNATURE, 53, 2, 2, BMP_BPP_24, 0, -1, 0);
		// A top-down image stores a negative height.
		add_file(BMP_SIGNATURE, 54, 2, 32'hFFFF_FFFE, BMP_BPP_24, 0, -1, 0);
		// A new file starting in the middle of the header.
		add_file(BMP_SIGNATURE, 54, 5, 3, BMP_BPP_24, 0, 20, 0);
		// The largest accepted width and height, each cut off in its pixels so that
		// the next start of file abandons it.
		add_file(BMP_SIGNATURE, 54, 4096, 1, BMP_BPP_24, 0, 60, 0);
		add_file(BMP_SIGNATURE, 54, 1, 4096, BMP_BPP_24, 0, 62, 0);
		send_queued();

		send_idle_pct = 51;
		recv_idle_pct = 26;
		add_random_files(PHASE_BYTES);
		send_queued();

		// No idling; the receiver stops long enough for the decoder to stall its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_armed   = 1'b1;
		add_file(BMP_SIGNATURE, 54, 4, 4, BMP_BPP_24, 0, -1, 0);
		send_queued();

		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d files in %0d bytes: all paddings, every header check,",
			file_count, byte_total);
		$display("size limits, restarts and a long stall; matched %0d pixels, %0d errors.",
			pixel_count, error_count);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bsd_pkg.sv
hw/rtl/bsd_parser.sv
hw/rtl/bsd_out_skid.sv
hw/rtl/bmp24_stream_decoder.sv
dv/bmp24_stream_decoder_checker.sv
dv/bmp24_stream_decoder_tb.sv
